/* sv/ise_pkg.sv */
// ---------------------------------------------------------------------------
// ise_pkg
// Shared types and constants of the interval set engine.
// ---------------------------------------------------------------------------
package ise_pkg;
	localparam int MaxRanges = 64;
	localparam int PositionBits = 32;
	localparam int IdxBits = $clog2(MaxRanges);
	localparam int CntBits = $clog2(MaxRanges + 1);

	typedef logic [PositionBits-1:0] pos_t;
	typedef logic [IdxBits-1:0] idx_t;
	typedef logic [CntBits-1:0] cnt_t;

	typedef enum logic [1:0] {
		KIND_ADD = 2'd0,
		KIND_SUB = 2'd1,
		KIND_POP = 2'd2,
		KIND_NOP = 2'd3
	} kind_t;

	typedef struct packed {
		logic [1:0] kind;
		pos_t range_start;
		pos_t range_end;
		pos_t center_position;
		pos_t chunk_length;
	} req_t;

	typedef struct packed {
		logic [31:0] chunk_start;
		logic [31:0] chunk_end;
		logic chunk_found;
		logic table_overflow;
		logic [6:0] range_count;
	} rsp_t;

	// One sequencer step each state; memory reads are registered and return in the next cycle.
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SCAN_RD,
		ST_SCAN_WT,
		ST_SCAN_EV,
		ST_ADD_HI_RD,
		ST_ADD_HI_WT,
		ST_ADD_HI_EV,
		ST_ADD_FIX,
		ST_SUB_CHK_RD,
		ST_SUB_CHK_WT,
		ST_SUB_CHK_EV,
		ST_SUB_RD,
		ST_SUB_WT,
		ST_SUB_EV,
		ST_POP_RD,
		ST_POP_WT,
		ST_POP_EV,
		ST_POP_DIV,
		ST_POP_FIN,
		ST_SHIFT_RD,
		ST_SHIFT_WT,
		ST_SHIFT_WR,
		ST_DONE
	} state_t;
endpackage

/* sv/ise_if.sv */
// ---------------------------------------------------------------------------
// ise_if
// Valid/ready channel carrying one payload.
// ---------------------------------------------------------------------------
interface ise_if #(parameter type payload_t = logic);
	logic valid;
	logic ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* sv/interval_set_engine.sv */
// ---------------------------------------------------------------------------
// interval_set_engine
// Sorted table of disjoint half-open ranges with add, subtract and pop.
// ---------------------------------------------------------------------------
// Each entry scanned passes through read, wait and evaluate states, and each entry
// shifted through read, wait and write states. A pop that splits inside a range
// waits for the divider's quotient. One transaction is in flight at a time; the
// next is accepted while the response waits. Reset empties the table at once.
module interval_set_engine (
	input logic clk,
	input logic arst_n,
	ise_if.sink in_ch,
	ise_if.source out_ch
);
	localparam int W = ise_pkg::PositionBits;
	localparam int N = ise_pkg::MaxRanges;
	localparam int IB = ise_pkg::IdxBits;
	localparam int CB = ise_pkg::CntBits;

	// Entry memory: start and end packed into one word.
	logic [2*W-1:0] mem [N];
	logic mem_we;
	ise_pkg::idx_t mem_waddr, mem_raddr, raddr_q;
	logic [2*W-1:0] mem_wdata, mem_rdata_q;
	ise_pkg::pos_t ra, rb;

	// The read address is held between reads so the data stays put while waiting.
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		mem_rdata_q <= mem[mem_raddr];
		raddr_q <= mem_raddr;
	end
	assign ra = mem_rdata_q[2*W-1:W];
	assign rb = mem_rdata_q[W-1:0];

	ise_pkg::state_t state_q, state_d;
	ise_pkg::req_t req_q;
	ise_pkg::cnt_t count_q, k_q, lo_q, hi_q;
	ise_pkg::pos_t s_q, e_q;          // working range
	ise_pkg::pos_t a_q, b_q;          // entry under work
	logic ovf_q, found_q, take_next_q, has_prev_q;
	ise_pkg::pos_t cs_q, ce_q, dp_q;
	// Shift job: when shift_up_q, entries [sh_lo_q, count) move up one,
	// then entry sh_lo_q gets ins_*; otherwise entries from sh_k_q up move down
	// sh_n_q places. ret_q is where the sequencer resumes.
	logic shift_up_q;
	ise_pkg::cnt_t sh_lo_q, sh_k_q, sh_n_q;
	ise_pkg::pos_t ins_s_q, ins_e_q;
	ise_pkg::state_t ret_q;
	logic rsp_valid_q;
	ise_pkg::rsp_t rsp_q;

	logic div_start, div_busy;
	ise_pkg::pos_t div_q;
	ise_pkg::pos_t dt;
	assign dt = (req_q.chunk_length == '0) ? W'(1) : req_q.chunk_length;

	// The divider samples its operands on start, while the chosen entry is on ra.
	ise_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(req_q.center_position - ra), .divisor(dt),
		.busy(div_busy), .quotient(div_q)
	);

	assign in_ch.ready = (state_q == ise_pkg::ST_IDLE);
	assign out_ch.valid = rsp_valid_q;
	assign out_ch.data = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ise_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	// Next-state values computed by the combinational step below.
	ise_pkg::cnt_t count_d, k_d, lo_d, hi_d, sh_lo_d, sh_k_d, sh_n_d;
	ise_pkg::pos_t s_d, e_d, a_d, b_d, cs_d, ce_d, dp_d, ins_s_d, ins_e_d;
	logic ovf_d, found_d, take_next_d, has_prev_d, shift_up_d;
	ise_pkg::state_t ret_d;
	logic done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (done) rsp_valid_q <= 1'b1;
			else if (out_ch.ready) rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) req_q <= in_ch.data;
		k_q <= k_d; lo_q <= lo_d; hi_q <= hi_d;
		s_q <= s_d; e_q <= e_d; a_q <= a_d; b_q <= b_d;
		ovf_q <= ovf_d; found_q <= found_d; take_next_q <= take_next_d;
		has_prev_q <= has_prev_d; cs_q <= cs_d; ce_q <= ce_d; dp_q <= dp_d;
		shift_up_q <= shift_up_d; sh_lo_q <= sh_lo_d; sh_k_q <= sh_k_d;
		sh_n_q <= sh_n_d; ins_s_q <= ins_s_d; ins_e_q <= ins_e_d; ret_q <= ret_d;
		if (done) begin
			rsp_q.chunk_start <= 32'(cs_q);
			rsp_q.chunk_end <= 32'(ce_q);
			rsp_q.chunk_found <= found_q;
			rsp_q.table_overflow <= ovf_q;
			rsp_q.range_count <= 7'(count_q);
		end
	end

	always_comb begin
		state_d = state_q;
		count_d = count_q; k_d = k_q; lo_d = lo_q; hi_d = hi_q;
		s_d = s_q; e_d = e_q; a_d = a_q; b_d = b_q;
		ovf_d = ovf_q; found_d = found_q; take_next_d = take_next_q;
		has_prev_d = has_prev_q; cs_d = cs_q; ce_d = ce_q; dp_d = dp_q;
		shift_up_d = shift_up_q; sh_lo_d = sh_lo_q; sh_k_d = sh_k_q;
		sh_n_d = sh_n_q; ins_s_d = ins_s_q; ins_e_d = ins_e_q; ret_d = ret_q;
		mem_we = 1'b0; mem_waddr = '0; mem_wdata = '0; mem_raddr = raddr_q;
		div_start = 1'b0; done = 1'b0;
		unique case (state_q)
			ise_pkg::ST_IDLE: begin
				if (in_ch.valid && in_ch.ready) state_d = ise_pkg::ST_DECODE;
			end
			ise_pkg::ST_DECODE: begin
				s_d = req_q.range_start; e_d = req_q.range_end;
				ovf_d = 1'b0; found_d = 1'b0; cs_d = '0; ce_d = '0; k_d = '0;
				state_d = ise_pkg::ST_DONE;
				unique case (req_q.kind)
					ise_pkg::KIND_ADD: if (s_d < e_d) state_d = ise_pkg::ST_SCAN_RD;
					ise_pkg::KIND_SUB: if (s_d < e_d) state_d = ise_pkg::ST_SUB_CHK_RD;
					ise_pkg::KIND_POP: if (count_q != '0) state_d = ise_pkg::ST_POP_RD;
					default: ;
				endcase
			end
			// Add: find lo, first entry with end >= s.
			ise_pkg::ST_SCAN_RD: begin
				if (k_q >= count_q) begin
					lo_d = k_q; hi_d = k_q; state_d = ise_pkg::ST_ADD_FIX;
				end else begin
					mem_raddr = IB'(k_q); state_d = ise_pkg::ST_SCAN_WT;
				end
			end
			ise_pkg::ST_SCAN_WT: state_d = ise_pkg::ST_SCAN_EV;
			ise_pkg::ST_SCAN_EV: begin
				if (rb < s_q) begin
					k_d = k_q + 1'b1; state_d = ise_pkg::ST_SCAN_RD;
				end else begin
					lo_d = k_q; hi_d = k_q;
					if (ra < s_q) s_d = ra;
					state_d = ise_pkg::ST_ADD_HI_RD;
				end
			end
			ise_pkg::ST_ADD_HI_RD: begin
				if (hi_q >= count_q) state_d = ise_pkg::ST_ADD_FIX;
				else begin
					mem_raddr = IB'(hi_q); state_d = ise_pkg::ST_ADD_HI_WT;
				end
			end
			ise_pkg::ST_ADD_HI_WT: state_d = ise_pkg::ST_ADD_HI_EV;
			ise_pkg::ST_ADD_HI_EV: begin
				if (ra <= req_q.range_end) begin
					if (rb > e_q) e_d = rb;
					hi_d = hi_q + 1'b1; state_d = ise_pkg::ST_ADD_HI_RD;
				end else state_d = ise_pkg::ST_ADD_FIX;
			end
			ise_pkg::ST_ADD_FIX: begin
				if (hi_q == lo_q) begin
					if (count_q >= CB'(N)) begin
						ovf_d = 1'b1; state_d = ise_pkg::ST_DONE;
					end else begin
						shift_up_d = 1'b1; sh_lo_d = lo_q; sh_k_d = count_q;
						ins_s_d = s_q; ins_e_d = e_q;
						ret_d = ise_pkg::ST_DONE; state_d = ise_pkg::ST_SHIFT_RD;
					end
				end else begin
					mem_we = 1'b1; mem_waddr = IB'(lo_q); mem_wdata = {s_q, e_q};
					shift_up_d = 1'b0; sh_lo_d = lo_q + 1'b1;
					sh_n_d = hi_q - lo_q - 1'b1; sh_k_d = hi_q;
					ret_d = ise_pkg::ST_DONE;
					state_d = (sh_n_d == '0) ? ise_pkg::ST_DONE : ise_pkg::ST_SHIFT_RD;
				end
			end
			// Subtract: a split on a full table drops the whole transaction.
			ise_pkg::ST_SUB_CHK_RD: begin
				if (k_q >= count_q) begin
					k_d = '0; state_d = ise_pkg::ST_SUB_RD;
				end else begin
					mem_raddr = IB'(k_q); state_d = ise_pkg::ST_SUB_CHK_WT;
				end
			end
			ise_pkg::ST_SUB_CHK_WT: state_d = ise_pkg::ST_SUB_CHK_EV;
			ise_pkg::ST_SUB_CHK_EV: begin
				if (ra < s_q && rb > e_q && count_q >= CB'(N)) begin
					ovf_d = 1'b1; state_d = ise_pkg::ST_DONE;
				end else begin
					k_d = k_q + 1'b1; state_d = ise_pkg::ST_SUB_CHK_RD;
				end
			end
			ise_pkg::ST_SUB_RD: begin
				if (k_q >= count_q) state_d = ise_pkg::ST_DONE;
				else begin
					mem_raddr = IB'(k_q); state_d = ise_pkg::ST_SUB_WT;
				end
			end
			ise_pkg::ST_SUB_WT: state_d = ise_pkg::ST_SUB_EV;
			ise_pkg::ST_SUB_EV: begin
				state_d = ise_pkg::ST_SUB_RD;
				k_d = k_q + 1'b1;
				if (rb > s_q && ra < e_q) begin
					if (ra < s_q && rb > e_q) begin
						mem_we = 1'b1; mem_waddr = IB'(k_q); mem_wdata = {ra, s_q};
						shift_up_d = 1'b1; sh_lo_d = k_q + 1'b1; sh_k_d = count_q;
						ins_s_d = e_q; ins_e_d = rb;
						k_d = k_q + 2'd2;
						ret_d = ise_pkg::ST_SUB_RD; state_d = ise_pkg::ST_SHIFT_RD;
					end else if (ra >= s_q && rb <= e_q) begin
						shift_up_d = 1'b0; sh_lo_d = k_q; sh_n_d = CB'(1);
						sh_k_d = k_q + 1'b1; k_d = k_q;
						ret_d = ise_pkg::ST_SUB_RD; state_d = ise_pkg::ST_SHIFT_RD;
					end else begin
						mem_we = 1'b1; mem_waddr = IB'(k_q);
						mem_wdata = {(ra >= s_q) ? e_q : ra, (rb <= e_q) ? s_q : rb};
					end
				end
			end
			// Pop: find first entry with start > center.
			ise_pkg::ST_POP_RD: begin
				if (k_q >= count_q) begin
					take_next_d = 1'b0; k_d = k_q - 1'b1;
					mem_raddr = IB'(k_d); state_d = ise_pkg::ST_POP_WT;
					has_prev_d = 1'b1;
				end else begin
					mem_raddr = IB'(k_q); state_d = ise_pkg::ST_SCAN_WT;
					state_d = ise_pkg::ST_POP_WT; take_next_d = 1'b1;
				end
			end
			ise_pkg::ST_POP_WT: state_d = ise_pkg::ST_POP_EV;
			ise_pkg::ST_POP_EV: begin
				// take_next_q marks a scan read; cleared means final entry read.
				if (take_next_q) begin
					if (ra <= req_q.center_position) begin
						dp_d = (rb < req_q.center_position) ?
							req_q.center_position - rb : '0;
						has_prev_d = 1'b1;
						k_d = k_q + 1'b1; state_d = ise_pkg::ST_POP_RD;
					end else begin
						if (k_q != '0 &&
						    !((ra - req_q.center_position) < dp_q)) begin
							k_d = k_q - 1'b1; take_next_d = 1'b0;
						end else begin
							take_next_d = 1'b0; has_prev_d = 1'b0;
						end
						mem_raddr = IB'(k_d); state_d = ise_pkg::ST_POP_WT;
						// has_prev_q cleared now means the next entry won.
						found_d = 1'b0;
						ovf_d = (k_q != '0 &&
							!((ra - req_q.center_position) < dp_q));
					end
				end else begin
					// ovf_q temporarily holds "previous entry chosen".
					a_d = ra; b_d = rb; ovf_d = 1'b0;
					take_next_d = !(ovf_q || (k_q + 1'b1 == count_q && has_prev_q
						&& ra <= req_q.center_position));
					if (rb - ra <= dt) begin
						cs_d = ra; ce_d = rb; found_d = 1'b1;
						shift_up_d = 1'b0; sh_lo_d = k_q; sh_n_d = CB'(1);
						sh_k_d = k_q + 1'b1; ret_d = ise_pkg::ST_DONE;
						state_d = ise_pkg::ST_SHIFT_RD;
					end else if (take_next_d) begin
						cs_d = ra; ce_d = ra + dt; found_d = 1'b1;
						mem_we = 1'b1; mem_waddr = IB'(k_q); mem_wdata = {ra + dt, rb};
						state_d = ise_pkg::ST_DONE;
					end else if (rb <= req_q.center_position) begin
						cs_d = rb - dt; ce_d = rb; found_d = 1'b1;
						mem_we = 1'b1; mem_waddr = IB'(k_q); mem_wdata = {ra, rb - dt};
						state_d = ise_pkg::ST_DONE;
					end else begin
						div_start = 1'b1; state_d = ise_pkg::ST_POP_DIV;
					end
				end
			end
			ise_pkg::ST_POP_DIV: begin
				if (!div_busy && !div_start) state_d = ise_pkg::ST_POP_FIN;
			end
			ise_pkg::ST_POP_FIN: begin : pop_fin
				logic [2*W-1:0] prod;
				ise_pkg::pos_t st, en;
				logic right;
				prod = div_q * dt;
				st = a_q + prod[W-1:0];
				right = (b_q - st) > dt;
				en = right ? st + dt : b_q;
				state_d = ise_pkg::ST_DONE;
				if (st > a_q && right && count_q >= CB'(N)) begin
					ovf_d = 1'b1;
				end else begin
					cs_d = st; ce_d = en; found_d = 1'b1;
					if (st > a_q && right) begin
						mem_we = 1'b1; mem_waddr = IB'(k_q); mem_wdata = {a_q, st};
						shift_up_d = 1'b1; sh_lo_d = k_q + 1'b1; sh_k_d = count_q;
						ins_s_d = en; ins_e_d = b_q; ret_d = ise_pkg::ST_DONE;
						state_d = ise_pkg::ST_SHIFT_RD;
					end else if (st > a_q) begin
						mem_we = 1'b1; mem_waddr = IB'(k_q); mem_wdata = {a_q, st};
					end else if (right) begin
						mem_we = 1'b1; mem_waddr = IB'(k_q); mem_wdata = {en, b_q};
					end else begin
						shift_up_d = 1'b0; sh_lo_d = k_q; sh_n_d = CB'(1);
						sh_k_d = k_q + 1'b1; ret_d = ise_pkg::ST_DONE;
						state_d = ise_pkg::ST_SHIFT_RD;
					end
				end
			end
			// Shift engine. Upward moves walk from the top entry down.
			ise_pkg::ST_SHIFT_RD: begin
				if (shift_up_q) begin
					if (sh_k_q == sh_lo_q) begin
						mem_we = 1'b1; mem_waddr = IB'(sh_lo_q);
						mem_wdata = {ins_s_q, ins_e_q};
						count_d = count_q + 1'b1; state_d = ret_q;
					end else begin
						mem_raddr = IB'(sh_k_q - 1'b1); state_d = ise_pkg::ST_SHIFT_WT;
					end
				end else begin
					if (sh_k_q >= count_q) begin
						count_d = count_q - sh_n_q; state_d = ret_q;
					end else begin
						mem_raddr = IB'(sh_k_q); state_d = ise_pkg::ST_SHIFT_WT;
					end
				end
			end
			ise_pkg::ST_SHIFT_WT: state_d = ise_pkg::ST_SHIFT_WR;
			ise_pkg::ST_SHIFT_WR: begin
				mem_we = 1'b1; mem_wdata = mem_rdata_q;
				if (shift_up_q) begin
					mem_waddr = IB'(sh_k_q); sh_k_d = sh_k_q - 1'b1;
				end else begin
					mem_waddr = IB'(sh_k_q - sh_n_q); sh_k_d = sh_k_q + 1'b1;
				end
				state_d = ise_pkg::ST_SHIFT_RD;
			end
			// The response register is refilled only once its transaction has left.
			ise_pkg::ST_DONE: begin
				if (!rsp_valid_q || out_ch.ready) begin
					done = 1'b1; state_d = ise_pkg::ST_IDLE;
				end
			end
			default: state_d = ise_pkg::ST_IDLE;
		endcase
	end
endmodule

/* sv/ise_div.sv */
// ---------------------------------------------------------------------------
// ise_div
// Restoring divider that returns the quotient one bit per cycle.
// ---------------------------------------------------------------------------
module ise_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input ise_pkg::pos_t dividend,
	input ise_pkg::pos_t divisor,
	output logic busy,
	output ise_pkg::pos_t quotient
);
	localparam int W = ise_pkg::PositionBits;
	localparam int CB = $clog2(W + 1);
	logic [CB-1:0] cnt_q;
	ise_pkg::pos_t q_q;
	ise_pkg::pos_t d_q;
	logic [W:0] r_q;
	logic [W:0] trial;

	assign trial = {r_q[W-1:0], q_q[W-1]} - {1'b0, d_q};
	assign busy = (cnt_q != '0);
	assign quotient = q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CB'(W);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			d_q <= divisor;
			r_q <= '0;
		end else if (busy) begin
			if (!trial[W]) begin
				r_q <= trial;
				q_q <= {q_q[W-2:0], 1'b1};
			end else begin
				r_q <= {r_q[W-1:0], q_q[W-1]};
				q_q <= {q_q[W-2:0], 1'b0};
			end
		end
	end
endmodule
